>>> rtl/lower_triangular_solve_assert.svh
// assertion macros for the lower-triangular solver checker
// used by lts_checker; relies on signals named clock and reset in scope
`ifndef LOWER_TRIANGULAR_SOLVE_ASSERT_SVH
`define LOWER_TRIANGULAR_SOLVE_ASSERT_SVH

// same-cycle implication, checked on every rising clock outside reset
`define LTS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lts assertion failed");

// next-cycle implication
`define LTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lts assertion failed");

`endif

>>> rtl/lts_pkg.sv
// shared types and constants of the lower-triangular solver
// no dependencies; used by lts_divider, lower_triangular_solve and lts_checker
package lts_pkg;

   localparam int MAX_SIZE_DEF = 64;
   localparam int ROW_W        = 6;
   localparam int DATA_W       = 32;
   localparam int SIZE_W       = 7;
   localparam int REQ_TDATA_W  = 80;
   localparam int RSP_TDATA_W  = 40;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   typedef logic signed [DATA_W-1:0]   q16_type;
   typedef logic signed [2*DATA_W-1:0] q32_type;
   typedef logic [ROW_W-1:0]           row_type;

endpackage

>>> rtl/lts_divider.sv
// iterative signed divider: Q32.32 numerator by Q16.16 denominator, Q16.16 result
// restoring, one quotient bit per cycle, truncates toward zero and saturates
// depends on lts_pkg
module lts_divider (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  lts_pkg::q32_type num,
   input  lts_pkg::q16_type den,
   output logic             done,
   output lts_pkg::q16_type quot
);

   typedef enum logic [1:0] {
      D_IDLE,
      D_CHECK,
      D_RUN,
      D_FIX
   } div_state_type;

   div_state_type    state_ff;
   lts_pkg::q32_type num_ff;
   lts_pkg::q16_type den_ff;
   logic [31:0]      rem_ff;
   logic [31:0]      quo_ff;
   logic [31:0]      dmag_ff;
   logic             neg_ff;
   logic             ovf_ff;
   logic [4:0]       cnt_ff;
   logic             done_ff;
   lts_pkg::q16_type quot_ff;

   logic [63:0] num_mag;
   logic [31:0] den_mag;
   logic [32:0] shifted;
   logic        ge;
   logic [31:0] rem_in;

   always_comb begin
      num_mag = num_ff[63] ? (~num_ff + 64'd1) : num_ff;
      den_mag = den_ff[31] ? (~den_ff + 32'd1) : den_ff;
      shifted = {rem_ff, quo_ff[31]};
      ge      = shifted >= {1'b0, dmag_ff};
      rem_in  = ge ? 32'(shifted - {1'b0, dmag_ff}) : shifted[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  num_ff   <= num;
                  den_ff   <= den;
                  state_ff <= D_CHECK;
               end
            end
            D_CHECK: begin
               // quotient of 2^32 or more saturates either way
               dmag_ff  <= den_mag;
               neg_ff   <= num_ff[63] ^ den_ff[31];
               ovf_ff   <= num_mag[63:32] >= den_mag;
               rem_ff   <= num_mag[63:32];
               quo_ff   <= num_mag[31:0];
               cnt_ff   <= 5'd31;
               state_ff <= (num_mag[63:32] >= den_mag) ? D_FIX : D_RUN;
            end
            D_RUN: begin
               rem_ff <= rem_in;
               quo_ff <= {quo_ff[30:0], ge};
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  state_ff <= D_FIX;
               end
            end
            D_FIX: begin
               priority if (neg_ff && (ovf_ff || quo_ff[31])) begin
                  quot_ff <= {1'b1, 31'd0};
               end else if (neg_ff) begin
                  quot_ff <= ~quo_ff + 32'd1;
               end else if (ovf_ff || quo_ff[31]) begin
                  quot_ff <= {1'b0, {31{1'b1}}};
               end else begin
                  quot_ff <= quo_ff;
               end
               done_ff  <= 1'b1;
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> rtl/lower_triangular_solve.sv
// off-diagonal request: store read, multiply, then accumulate overlapped with the next
// accept. diagonal request: the result is set by the 32-step restoring divider;
// quotients of 2^32 or more skip its steps, and a zero diagonal skips the divider.
// the next request is taken the cycle after the result register loads.
// synchronous active-high reset clears the sequencer, the running sum and
// matrix_size (to 64); the solution store is not cleared.
module lower_triangular_solve #(
   parameter int MAX_SIZE = lts_pkg::MAX_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [lts_pkg::SIZE_W-1:0]        csr_wr_data,  // matrix_size
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // row_index[5:0], col_index[11:6], coeff[43:12], rhs[75:44], zero fill
   input  logic [lts_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // x_value[31:0], solved_row[37:32], zero fill
   output logic [lts_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              rsp_tuser     // divide_by_zero
);

   localparam int IdxW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_ACC,
      S_NUMER,
      S_DIV,
      S_DONE
   } state_type;

   localparam lts_pkg::q32_type SumMax = {1'b0, {63{1'b1}}};
   localparam lts_pkg::q32_type SumMin = {1'b1, 63'd0};

   state_type                 state_ff;
   logic [lts_pkg::SIZE_W-1:0] size_ff;
   lts_pkg::q32_type          sum_ff;
   lts_pkg::q32_type          prod_ff;
   lts_pkg::row_type          row_ff;
   lts_pkg::q16_type          coeff_ff;
   lts_pkg::q16_type          rhs_ff;
   lts_pkg::q16_type          rd_ff;
   lts_pkg::q16_type          x_ff;
   logic                      dz_ff;
   logic                      rsp_valid_ff;
   lts_pkg::q16_type          rsp_x_ff;
   lts_pkg::row_type          rsp_row_ff;
   logic                      rsp_last_ff;
   logic                      rsp_dz_ff;

   lts_pkg::q16_type store [MAX_SIZE];

   lts_pkg::row_type req_row;
   lts_pkg::row_type req_col;
   lts_pkg::q16_type req_coeff;
   lts_pkg::q16_type req_rhs;
   logic             req_accept;
   logic             req_ignore;
   state_type        accept_state;
   logic             out_free;
   logic             store_we;
   logic             div_start;
   logic             div_done;
   lts_pkg::q16_type div_quot;
   logic [64:0]      acc_wide;
   logic [64:0]      numer_wide;
   lts_pkg::q32_type sum_in;
   lts_pkg::q32_type numer;
   logic             last_in;

   function automatic lts_pkg::q32_type clamp65(input logic [64:0] v);
      if (v[64] != v[63]) begin
         return v[64] ? SumMin : SumMax;
      end
      return v[63:0];
   endfunction

   always_comb begin
      req_row    = req_tdata[5:0];
      req_col    = req_tdata[11:6];
      req_coeff  = req_tdata[43:12];
      req_rhs    = req_tdata[75:44];
      req_tready = (state_ff == S_IDLE) || (state_ff == S_ACC);
      req_accept = req_tvalid && req_tready;
      req_ignore = (req_col > req_row) || ({1'b0, req_row} >= size_ff) ||
                   (int'(req_row) >= MAX_SIZE);
      priority if (req_ignore) begin
         accept_state = S_IDLE;
      end else if (req_col == req_row) begin
         accept_state = S_NUMER;
      end else begin
         accept_state = S_MUL;
      end
      out_free   = !rsp_valid_ff || rsp_tready;
      store_we   = (state_ff == S_DONE) && out_free;
      div_start  = (state_ff == S_NUMER) && (coeff_ff != '0);
      acc_wide   = {sum_ff[63], sum_ff} + {prod_ff[63], prod_ff};
      sum_in     = clamp65(acc_wide);
      // rhs widened to Q32.32 minus the running sum
      numer_wide = {{17{rhs_ff[31]}}, rhs_ff, 16'd0} - {sum_ff[63], sum_ff};
      numer      = clamp65(numer_wide);
      last_in    = ({1'b0, row_ff} + lts_pkg::SIZE_W'(1)) == size_ff;
   end

   lts_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (numer),
      .den   (coeff_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_ff <= store[IdxW'(req_col)];
      end
      if (store_we) begin
         store[IdxW'(row_ff)] <= x_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= lts_pkg::SIZE_RESET;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         if (req_accept) begin
            row_ff   <= req_row;
            coeff_ff <= req_coeff;
            rhs_ff   <= req_rhs;
         end
         // a result loaded in the same cycle keeps the valid set
         if (rsp_valid_ff && rsp_tready && !store_we) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  state_ff <= accept_state;
               end
            end
            S_MUL: begin
               prod_ff  <= rd_ff * coeff_ff;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               sum_ff   <= sum_in;
               state_ff <= req_accept ? accept_state : S_IDLE;
            end
            S_NUMER: begin
               dz_ff <= coeff_ff == '0;
               if (coeff_ff == '0) begin
                  x_ff     <= '0;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  x_ff     <= div_quot;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_x_ff     <= x_ff;
                  rsp_row_ff   <= row_ff;
                  rsp_last_ff  <= last_in;
                  rsp_dz_ff    <= dz_ff;
                  sum_ff       <= '0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_row_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_dz_ff;

endmodule

>>> rtl/lts_checker.sv
// port-level checks of the lower-triangular solver, bound to its top level
// depends on lts_pkg and lower_triangular_solve_assert.svh
`include "lower_triangular_solve_assert.svh"

module lts_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lts_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   // a stalled result keeps its payload
   `LTS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // zero diagonal forces the solved value to zero
   `LTS_ASSERT_NOW(a_dz_zero, rsp_tvalid && rsp_tuser, rsp_tdata[31:0] == '0)

   // a new result is only loaded while the sequencer is busy finishing a row
   `LTS_ASSERT_NOW(a_rsp_from_busy, $rose(rsp_tvalid), $past(!req_tready))

endmodule

bind lower_triangular_solve lts_checker u_lts_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 100ps
// self-checking bench for lower_triangular_solve: forward substitution of L x = b in Q16.16
// depends on lts_pkg and the lower_triangular_solve rtl; needs no files or arguments
module tb;

   localparam int RANDOM_ITEMS  = 1500;
   localparam int SETTLE_CYCLES = 60;
   localparam int STALL_LIMIT   = 5000;
   localparam int REPORT_LIMIT  = 30;

   typedef logic [lts_pkg::SIZE_W-1:0] size_type;

   typedef struct packed {
      lts_pkg::q16_type x_value;
      lts_pkg::row_type solved_row;
      logic             last;
      logic             divide_by_zero;
   } solution_type;

   typedef enum logic {STEP_SIZE, STEP_REQUEST} step_kind_type;

   typedef struct packed {
      step_kind_type    kind;
      size_type         new_size;
      lts_pkg::row_type row;
      lts_pkg::row_type col;
      lts_pkg::q16_type coeff;
      lts_pkg::q16_type rhs;
      logic             known;
      lts_pkg::q16_type x;
      logic             last;
      logic             dz;
   } step_type;

   // kind, size, row, col, coeff, rhs, known result?, x, last, divide_by_zero
   localparam step_type OPENING [25] = '{
      '{STEP_REQUEST, 7'd0, 6'd0, 6'd0, 32'h0001_0000, 32'h0003_0000, 1'b1, 32'h0003_0000, 1'b0, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd0, 6'd5, 32'h1234_5678, 32'h0000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd1, 6'd0, 32'h0002_0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd1, 6'd1, 32'h0001_0000, 32'h0007_0000, 1'b1, 32'h0001_0000, 1'b0, 1'b0},
      '{STEP_SIZE,    7'd1, 6'd0, 6'd0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      // zero diagonal
      '{STEP_REQUEST, 7'd0, 6'd0, 6'd0, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0, 1'b1, 1'b1},
      // row outside the system size
      '{STEP_REQUEST, 7'd0, 6'd1, 6'd0, 32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd0, 6'd0, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd0, 6'd0, 32'h0000_0001, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd0, 6'd0, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0001_0000, 1'b1, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd0, 6'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b1, 1'b0},
      '{STEP_SIZE,    7'd64, 6'd0, 6'd0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd63, 6'd0, 32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd63, 6'd63, 32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      // size beyond the largest row: last never set
      '{STEP_SIZE,    7'd127, 6'd0, 6'd0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd63, 6'd63, 32'h0001_0000, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0},
      // rows out of order, running sum driven into positive saturation
      '{STEP_REQUEST, 7'd0, 6'd5, 6'd0, 32'h8000_0000, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd5, 6'd0, 32'h8000_0000, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd5, 6'd0, 32'h8000_0000, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd5, 6'd5, 32'h0001_0000, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      // negative sum saturation, then numerator saturation
      '{STEP_REQUEST, 7'd0, 6'd6, 6'd0, 32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd6, 6'd0, 32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd6, 6'd0, 32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd6, 6'd6, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
      '{STEP_REQUEST, 7'd0, 6'd7, 6'd7, 32'h0001_0000, 32'h0001_2345, 1'b0, 32'h0, 1'b0, 1'b0}
   };

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            csr_wr_en   = 1'b0;
   size_type                        csr_wr_data = '0;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [lts_pkg::REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [lts_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            rsp_tuser;

   // solver model state
   lts_pkg::q16_type x_store [64];
   bit               x_known [64];
   lts_pkg::q32_type row_sum    = '0;
   size_type         solve_size = lts_pkg::SIZE_RESET;

   solution_type pending_solutions [$];
   int           mismatches         = 0;
   int           requests_counted   = 0;
   int unsigned  sender_idle_pct    = 0;
   int unsigned  receiver_stall_pct = 0;

   lower_triangular_solve dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic lts_pkg::q32_type saturate_add(input lts_pkg::q32_type a,
                                                     input lts_pkg::q32_type b,
                                                     input bit minus);
      logic [64:0] wide;
      wide = minus ? {a[63], a} - {b[63], b} : {a[63], a} + {b[63], b};
      if (wide[64] == wide[63]) return wide[63:0];
      return wide[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
   endfunction

   // Q32.32 over Q16.16 gives Q16.16, truncated toward zero, then clamped to 32 bits
   function automatic lts_pkg::q16_type quotient(input lts_pkg::q32_type numer,
                                                 input lts_pkg::q16_type den);
      lts_pkg::q32_type wide_d;
      logic [63:0]      mag_n;
      logic [63:0]      mag_d;
      logic [63:0]      q;
      wide_d = den;
      mag_n  = numer[63] ? -numer : numer;
      mag_d  = wide_d[63] ? -wide_d : wide_d;
      q      = mag_n / mag_d;
      if (numer[63] == den[31]) return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      return (q >= 64'h8000_0000) ? 32'h8000_0000 : -q[31:0];
   endfunction

   // returns 1 when the request solves a row; used is 0 for requests the solver ignores
   function automatic bit forward_substitute(input lts_pkg::row_type r,
                                             input lts_pkg::row_type c,
                                             input lts_pkg::q16_type coeff,
                                             input lts_pkg::q16_type rhs,
                                             output solution_type sol, output bit used);
      lts_pkg::q32_type wide_x;
      lts_pkg::q32_type wide_c;
      sol  = '0;
      used = 1'b0;
      if (c > r || {1'b0, r} >= solve_size) return 1'b0;
      used = 1'b1;
      if (c < r) begin
         wide_x  = x_store[c];
         wide_c  = coeff;
         row_sum = saturate_add(row_sum, wide_x * wide_c, 1'b0);
         return 1'b0;
      end
      sol.solved_row     = r;
      sol.last           = ({1'b0, r} + 7'd1 == solve_size);
      sol.divide_by_zero = (coeff == 0);
      if (coeff == 0) begin
         sol.x_value = '0;
      end else begin
         wide_x      = rhs;
         sol.x_value = quotient(saturate_add(wide_x <<< 16, row_sum, 1'b1), coeff);
      end
      x_store[r] = sol.x_value;
      x_known[r] = 1'b1;
      row_sum    = '0;
      return 1'b1;
   endfunction

   function automatic lts_pkg::q16_type rand_value(input int unsigned zero_pct,
                                                   input int unsigned lo,
                                                   input int unsigned hi);
      int unsigned      pick;
      lts_pkg::q16_type mag;
      pick = $urandom_range(99);
      if (pick < zero_pct) return '0;
      if (pick < zero_pct + 10) return $urandom;
      mag = $urandom_range(hi, lo);
      return $urandom_range(1) ? -mag : mag;
   endfunction

   // called at a falling edge; returns at the falling edge after the request is taken
   task automatic send_request(input lts_pkg::row_type r, input lts_pkg::row_type c,
                               input lts_pkg::q16_type coeff, input lts_pkg::q16_type rhs,
                               input bit known = 1'b0,
                               input solution_type known_sol = '0);
      solution_type sol;
      bit           produces;
      bit           used;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {4'b0, rhs, coeff, c, r};
      do @(posedge clock); while (!req_tready);
      produces = forward_substitute(r, c, coeff, rhs, sol, used);
      if (used) requests_counted++;
      if (produces) pending_solutions.push_back(known ? known_sol : sol);
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_tvalid = 1'b0;
      while (pending_solutions.size() != 0) @(negedge clock);
   endtask

   task automatic write_size(input size_type value);
      hold_until_drained();
      // off-diagonal requests leave no result behind, let them finish
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en  = 1'b0;
      solve_size = value;
   endtask

   // random request that may break the running row sequence
   task automatic send_noise();
      lts_pkg::row_type r;
      lts_pkg::row_type c;
      r = lts_pkg::row_type'($urandom);
      c = lts_pkg::row_type'($urandom);
      if (c < r && {1'b0, r} < solve_size && !x_known[c]) c = r;
      send_request(r, c, $urandom, $urandom);
   endtask

   task automatic solve_system(input int rows);
      for (int r = 0; r < rows; r++) begin
         if ($urandom_range(99) < 2) hold_until_drained();
         for (int c = 0; c < r; c++) begin
            if (!x_known[c]) continue;
            // large rows stay sparse
            if (r > 8 && $urandom_range(r - 1) >= 4) continue;
            if ($urandom_range(99) < 4) send_noise();
            send_request(lts_pkg::row_type'(r), lts_pkg::row_type'(c),
                         rand_value(5, 0, 32'h0002_0000), $urandom);
         end
         // a skipped diagonal lets the sum run on into the next row
         if ($urandom_range(99) < 3) continue;
         if ($urandom_range(99) < 4) send_noise();
         send_request(lts_pkg::row_type'(r), lts_pkg::row_type'(r),
                      rand_value(5, 32'h8000, 32'h0004_0000),
                      rand_value(3, 0, 32'h0010_0000));
      end
   endtask

   function automatic size_type pick_size();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 60) return size_type'($urandom_range(8, 1));
      if (pick < 80) return size_type'($urandom_range(24, 9));
      if (pick < 88) return size_type'($urandom_range(63, 25));
      if (pick < 96) return 7'd64;
      return 7'd127;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      end
   endtask

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin : rsp_check
      solution_type seen;
      solution_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.x_value        = rsp_tdata[31:0];
         seen.solved_row     = rsp_tdata[37:32];
         seen.last           = rsp_tlast;
         seen.divide_by_zero = rsp_tuser;
         if (pending_solutions.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected result, expected none, actual x %h row %0d",
                        $time, seen.x_value, seen.solved_row);
         end else begin
            want = pending_solutions.pop_front();
            check_field("x_value", want.x_value, seen.x_value);
            check_field("solved_row", 32'(want.solved_row), 32'(seen.solved_row));
            check_field("last", 32'(want.last), 32'(seen.last));
            check_field("divide_by_zero", 32'(want.divide_by_zero),
                        32'(seen.divide_by_zero));
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[lower_triangular_solve] ERROR");
      $finish;
   end

   initial begin : stimulus
      int           random_start;
      int           rows;
      bit           first_system;
      solution_type table_result;
      size_type     next_size;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (OPENING[i]) begin
         if (OPENING[i].kind == STEP_SIZE) begin
            write_size(OPENING[i].new_size);
         end else begin
            table_result.x_value        = OPENING[i].x;
            table_result.solved_row     = OPENING[i].row;
            table_result.last           = OPENING[i].last;
            table_result.divide_by_zero = OPENING[i].dz;
            send_request(OPENING[i].row, OPENING[i].col, OPENING[i].coeff, OPENING[i].rhs,
                         OPENING[i].known, table_result);
         end
      end

      random_start = requests_counted;
      first_system = 1'b1;
      while (requests_counted - random_start < RANDOM_ITEMS) begin
         case (((requests_counted - random_start) * 5) / RANDOM_ITEMS)
            1: begin
               sender_idle_pct    = 83;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 83;
            end
            3: begin
               sender_idle_pct    = 31;
               receiver_stall_pct = 31;
            end
            default: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
         endcase
         if (first_system || $urandom_range(2) != 0) begin
            next_size = pick_size();
            write_size(next_size);
         end
         first_system = 1'b0;
         rows = (solve_size > 64) ? 64 : int'(solve_size);
         if ($urandom_range(9) == 0) rows = $urandom_range(rows, 1);
         solve_system(rows);
      end

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("[lower_triangular_solve] OK");
      else
         $display("[lower_triangular_solve] ERROR");
      $finish;
   end

endmodule
